/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrapper with clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion checked on the rising clock edge, off while in reset.
`define PDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication that must hold from one cycle to the next.
`define PDC_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  `PDC_ASSERT(lbl, clk, rstn, (pre) |=> (post), msg)

`endif

/* src/pdc_pkg.sv */
// ----------------------------------------------------------------------------
// Packet deframer package
// Shared constants, types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package pdc_pkg;

  localparam int MAX_BODY_DEF = 32;
  localparam int LEN_W        = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  localparam logic [7:0]  START_RESET = 8'd126;
  localparam logic [7:0]  END_RESET   = 8'd127;
  localparam logic [5:0]  LIMIT_RESET = 6'd32;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef enum logic [11:0] {
    PH_HUNT   = 12'b0000_0000_0001,
    PH_VER    = 12'b0000_0000_0010,
    PH_TYPE   = 12'b0000_0000_0100,
    PH_FLAGS  = 12'b0000_0000_1000,
    PH_REQ_HI = 12'b0000_0001_0000,
    PH_REQ_LO = 12'b0000_0010_0000,
    PH_LEN_HI = 12'b0000_0100_0000,
    PH_LEN_LO = 12'b0000_1000_0000,
    PH_BODY   = 12'b0001_0000_0000,
    PH_CRC_HI = 12'b0010_0000_0000,
    PH_CRC_LO = 12'b0100_0000_0000,
    PH_END    = 12'b1000_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0]       version;
    logic [7:0]       pkt_kind;
    logic [7:0]       flags;
    logic [15:0]      request;
    logic [LEN_W-1:0] length;
    logic             bank;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_push_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/pdc_front.sv */
// ----------------------------------------------------------------------------
// Packet deframer front end
// Parses the byte stream, checks the CRC and writes payload bytes to a bank.
// ----------------------------------------------------------------------------
module pdc_front #(
  parameter int MAX_BODY = pdc_pkg::MAX_BODY_DEF,
  parameter int AW       = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rx_valid_i,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             full_i,
  input  logic                             cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                             wr_en_o,
  output logic [AW:0]                      wr_addr_o,
  output logic [7:0]                       wr_data_o,
  output pdc_pkg::desc_push_t              push_o
);

  pdc_pkg::phase_e phase_q, phase_d;
  logic [7:0]  start_q, end_q;
  logic [5:0]  limit_q;
  logic [7:0]  ver_q, ver_d, type_q, type_d, flags_q, flags_d;
  logic [15:0] req_q, req_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [pdc_pkg::LEN_W-1:0] len_q, len_d, fill_q, fill_d;
  logic [15:0] crc_q, crc_d, rcrc_q, rcrc_d;
  logic        bank_q, bank_d;
  logic        accept;
  logic [15:0] len_full, eff_limit, crc_next;
  logic [pdc_pkg::LEN_W-1:0] fill_inc;

  assign accept    = rx_valid_i && !full_i;
  assign len_full  = {len_hi_q, rx_byte_i};
  assign eff_limit = (16'(limit_q) > 16'(MAX_BODY)) ? 16'(MAX_BODY) : 16'(limit_q);
  assign crc_next  = pdc_pkg::crc16_byte(crc_q, rx_byte_i);
  assign fill_inc  = fill_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    ver_d    = ver_q;
    type_d   = type_q;
    flags_d  = flags_q;
    req_d    = req_q;
    len_hi_d = len_hi_q;
    len_d    = len_q;
    fill_d   = fill_q;
    crc_d    = crc_q;
    rcrc_d   = rcrc_q;
    bank_d   = bank_q;
    wr_en_o  = 1'b0;
    push_o   = '0;
    if (accept) begin
      case (phase_q)
        pdc_pkg::PH_HUNT: begin
          if (rx_byte_i == start_q) begin
            crc_d   = pdc_pkg::CRC_INIT;
            fill_d  = '0;
            phase_d = pdc_pkg::PH_VER;
          end
        end
        pdc_pkg::PH_VER: begin
          ver_d   = rx_byte_i;
          crc_d   = crc_next;
          phase_d = pdc_pkg::PH_TYPE;
        end
        pdc_pkg::PH_TYPE: begin
          type_d  = rx_byte_i;
          crc_d   = crc_next;
          phase_d = pdc_pkg::PH_FLAGS;
        end
        pdc_pkg::PH_FLAGS: begin
          flags_d = rx_byte_i;
          crc_d   = crc_next;
          phase_d = pdc_pkg::PH_REQ_HI;
        end
        pdc_pkg::PH_REQ_HI: begin
          req_d   = {rx_byte_i, 8'h00};
          crc_d   = crc_next;
          phase_d = pdc_pkg::PH_REQ_LO;
        end
        pdc_pkg::PH_REQ_LO: begin
          req_d   = {req_q[15:8], rx_byte_i};
          crc_d   = crc_next;
          phase_d = pdc_pkg::PH_LEN_HI;
        end
        pdc_pkg::PH_LEN_HI: begin
          len_hi_d = rx_byte_i;
          crc_d    = crc_next;
          phase_d  = pdc_pkg::PH_LEN_LO;
        end
        pdc_pkg::PH_LEN_LO: begin
          crc_d = crc_next;
          len_d = len_full[pdc_pkg::LEN_W-1:0];
          if (len_full > eff_limit) begin
            phase_d = pdc_pkg::PH_HUNT;
          end else if (len_full == 16'd0) begin
            phase_d = pdc_pkg::PH_CRC_HI;
          end else begin
            fill_d  = '0;
            phase_d = pdc_pkg::PH_BODY;
          end
        end
        pdc_pkg::PH_BODY: begin
          wr_en_o = 1'b1;
          fill_d  = fill_inc;
          crc_d   = crc_next;
          if (fill_inc >= len_q) begin
            phase_d = pdc_pkg::PH_CRC_HI;
          end
        end
        pdc_pkg::PH_CRC_HI: begin
          rcrc_d  = {rx_byte_i, 8'h00};
          phase_d = pdc_pkg::PH_CRC_LO;
        end
        pdc_pkg::PH_CRC_LO: begin
          rcrc_d  = {rcrc_q[15:8], rx_byte_i};
          phase_d = pdc_pkg::PH_END;
        end
        pdc_pkg::PH_END: begin
          phase_d = pdc_pkg::PH_HUNT;
          if (rx_byte_i == end_q && crc_q == rcrc_q) begin
            push_o.valid         = 1'b1;
            push_o.desc.version  = ver_q;
            push_o.desc.pkt_kind = type_q;
            push_o.desc.flags    = flags_q;
            push_o.desc.request  = req_q;
            push_o.desc.length   = len_q;
            push_o.desc.bank     = bank_q;
            bank_d               = !bank_q;
          end
        end
        default: begin
          phase_d = pdc_pkg::PH_HUNT;
        end
      endcase
    end
  end

  assign wr_addr_o = {bank_q, fill_q[AW-1:0]};
  assign wr_data_o = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pdc_pkg::PH_HUNT;
      bank_q  <= 1'b0;
      fill_q  <= '0;
      crc_q   <= pdc_pkg::CRC_INIT;
      start_q <= pdc_pkg::START_RESET;
      end_q   <= pdc_pkg::END_RESET;
      limit_q <= pdc_pkg::LIMIT_RESET;
    end else begin
      phase_q <= phase_d;
      bank_q  <= bank_d;
      fill_q  <= fill_d;
      crc_q   <= crc_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pdc_pkg::CFG_START: start_q <= cfg_wdata_i;
          pdc_pkg::CFG_END:   end_q   <= cfg_wdata_i;
          pdc_pkg::CFG_LIMIT: limit_q <= cfg_wdata_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ver_q    <= ver_d;
    type_q   <= type_d;
    flags_q  <= flags_d;
    req_q    <= req_d;
    len_hi_q <= len_hi_d;
    len_q    <= len_d;
    rcrc_q   <= rcrc_d;
  end

endmodule

/* src/pdc_queue.sv */
// ----------------------------------------------------------------------------
// Packet descriptor queue
// Two-entry queue of accepted packets, one entry per payload bank.
// ----------------------------------------------------------------------------
module pdc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdc_pkg::desc_push_t push_i,
  input  logic                pop_i,
  output logic                head_valid_o,
  output pdc_pkg::desc_t      head_o,
  output logic                full_o
);

  pdc_pkg::desc_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign head_valid_o = (count_q != 2'd0);
  assign full_o       = (count_q == 2'd2);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i.valid) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.desc;
    end
  end

endmodule

/* src/pdc_back.sv */
// ----------------------------------------------------------------------------
// Packet deframer back end
// Holds the payload banks and reads packets out as one result per byte.
// ----------------------------------------------------------------------------
module pdc_back #(
  parameter int MAX_BODY = pdc_pkg::MAX_BODY_DEF,
  parameter int AW       = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [AW:0]                    wr_addr_i,
  input  logic [7:0]                     wr_data_i,
  input  logic                           head_valid_i,
  input  pdc_pkg::desc_t                 head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     pkt_version_o,
  output logic [7:0]                     pkt_type_o,
  output logic [7:0]                     pkt_flags_o,
  output logic [15:0]                    request_tag_o,
  output logic [pdc_pkg::LEN_W-1:0]      body_length_o,
  output logic [4:0]                     body_index_o,
  output logic [7:0]                     body_byte_o,
  output logic                           last_of_packet_o
);

  logic [7:0] mem [2*(2**AW)];
  logic [7:0] rd_data_q;
  logic [pdc_pkg::LEN_W-1:0] idx_q;
  logic        rd_pend_q, out_valid_q;
  logic        issue, is_zero, is_last;
  logic [AW:0] rd_addr;
  pdc_pkg::desc_t pend_desc_q;
  logic [4:0]  pend_idx_q;
  logic        pend_zero_q, pend_last_q;

  assign issue   = head_valid_i && !rd_pend_q && (!out_valid_q || !out_stall_i);
  assign is_zero = (head_i.length == '0);
  assign is_last = is_zero || ((idx_q + 1'b1) == head_i.length);
  assign pop_o   = issue && is_last;
  assign rd_addr = {head_i.bank, idx_q[AW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q   <= mem[rd_addr];
      pend_desc_q <= head_i;
      pend_idx_q  <= is_zero ? 5'd0 : idx_q[4:0];
      pend_zero_q <= is_zero;
      pend_last_q <= is_last;
    end
    if (rd_pend_q) begin
      pkt_version_o    <= pend_desc_q.version;
      pkt_type_o       <= pend_desc_q.pkt_kind;
      pkt_flags_o      <= pend_desc_q.flags;
      request_tag_o    <= pend_desc_q.request;
      body_length_o    <= pend_desc_q.length;
      body_index_o     <= pend_idx_q;
      body_byte_o      <= pend_zero_q ? 8'h00 : rd_data_q;
      last_of_packet_o <= pend_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= issue;
      if (issue) begin
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/packet_deframer_crc_check_top.sv */
// ----------------------------------------------------------------------------
// Packet deframer with CRC-16 check, top level
// Front parser and back readout joined by a two-entry packet queue.
// ----------------------------------------------------------------------------
// Received bytes stall only while both payload banks hold packets that are
// not yet read out. An accepted packet passes the queue, the registered
// bank read and the output register; a bank read is not issued while one
// is still pending, so results are read out one byte at a time.
// Reset clears the parser, the queue and the output valid flag at once and
// restores the register defaults; the payload banks are not cleared.
module packet_deframer_crc_check_top #(
  parameter int MAX_BODY = pdc_pkg::MAX_BODY_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rx_valid_i,
  output logic                           rx_stall_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     pkt_version_o,
  output logic [7:0]                     pkt_type_o,
  output logic [7:0]                     pkt_flags_o,
  output logic [15:0]                    request_tag_o,
  output logic [pdc_pkg::LEN_W-1:0]      body_length_o,
  output logic [4:0]                     body_index_o,
  output logic [7:0]                     body_byte_o,
  output logic                           last_of_packet_o
);

  localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;

  logic                wr_en;
  logic [AW:0]         wr_addr;
  logic [7:0]          wr_data;
  pdc_pkg::desc_push_t push;
  pdc_pkg::desc_t      head;
  logic                head_valid, pop, full;

  assign rx_stall_o = full;

  pdc_front #(.MAX_BODY(MAX_BODY), .AW(AW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_byte_i   (rx_byte_i),
    .full_i      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push)
  );

  pdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .full_o       (full)
  );

  pdc_back #(.MAX_BODY(MAX_BODY), .AW(AW)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_en_i          (wr_en),
    .wr_addr_i        (wr_addr),
    .wr_data_i        (wr_data),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pkt_version_o    (pkt_version_o),
    .pkt_type_o       (pkt_type_o),
    .pkt_flags_o      (pkt_flags_o),
    .request_tag_o    (request_tag_o),
    .body_length_o    (body_length_o),
    .body_index_o     (body_index_o),
    .body_byte_o      (body_byte_o),
    .last_of_packet_o (last_of_packet_o)
  );

endmodule

/* src/pdc_checker.sv */
// ----------------------------------------------------------------------------
// Packet deframer port checker
// Checks result ordering and output handshake on the top-level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [pdc_pkg::LEN_W-1:0] body_length_o,
  input logic [4:0]                body_index_o,
  input logic [7:0]                body_byte_o,
  input logic                      last_of_packet_o
);

  `PDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(body_byte_o) && $stable(body_index_o), "stalled result changed")
  `PDC_ASSERT(a_zero_is_last, clk_i, rst_ni,
    out_valid_o && (body_length_o == '0) |->
    last_of_packet_o && (body_index_o == 5'd0) && (body_byte_o == 8'h00),
    "empty packet result malformed")
  `PDC_ASSERT(a_last_index, clk_i, rst_ni,
    out_valid_o && last_of_packet_o && (body_length_o != '0) |->
    body_index_o == 5'(body_length_o - 6'd1), "last result not at final index")
  `PDC_ASSERT(a_index_range, clk_i, rst_ni,
    out_valid_o && !last_of_packet_o |->
    (body_length_o != '0) && (6'(body_index_o) < body_length_o), "result index out of range")

endmodule

bind packet_deframer_crc_check_top pdc_checker u_pdc_checker (.*);
